>>> rtl/core/rv64cs_pkg.sv
// shared types, constants and decode function for the rv64 subset core step unit
package rv64cs_pkg;

  localparam int unsigned MemWords = 4096;
  localparam int unsigned MemAw    = $clog2(MemWords);
  localparam int unsigned NumRegs  = 32;
  localparam int unsigned RegAw    = $clog2(NumRegs);
  localparam int unsigned Xlen     = 64;
  localparam int unsigned PcW      = 12;

  localparam logic [Xlen-1:0]  SpReset = 64'd16384;
  localparam logic [RegAw-1:0] SpIdx   = 5'd2;

  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6f;

  localparam logic [6:0] F7_ADD = 7'h00;
  localparam logic [6:0] F7_SUB = 7'h20;

  localparam logic [2:0] F3_ADD   = 3'd0;
  localparam logic [2:0] F3_DWORD = 3'd3;
  localparam logic [2:0] F3_BEQ   = 3'd0;
  localparam logic [2:0] F3_BNE   = 3'd1;
  localparam logic [2:0] F3_BLT   = 3'd4;
  localparam logic [2:0] F3_BGE   = 3'd5;

  typedef enum logic [1:0] {
    REQ_WR    = 2'd0,
    REQ_EXEC  = 2'd1,
    REQ_RDREG = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_HALT = 2'd1,
    ST_BAD  = 2'd2,
    ST_ACC  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_ADDI,
    OP_LD,
    OP_SD,
    OP_BR,
    OP_JAL,
    OP_BAD
  } op_e;

  typedef struct packed {
    req_e        req_type;
    logic [11:0] mem_addr;
    logic [31:0] mem_data;
    logic [4:0]  reg_index;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [PcW-1:0]     pc_now;
    logic signed [63:0] reg_value;
  } rsp_t;

  typedef struct packed {
    logic             en;
    logic [MemAw-1:0] addr;
    logic [31:0]      data;
  } mem_wr_t;

  typedef struct packed {
    logic             en;
    logic [RegAw-1:0] addr;
    logic [Xlen-1:0]  data;
  } rf_wr_t;

  typedef struct packed {
    logic             rf_we;
    logic [Xlen-1:0]  rf_wdata;
    logic [PcW-1:0]   next_pc;
    logic [MemAw-1:0] lo_addr;
    logic [MemAw-1:0] hi_addr;
    logic [31:0]      st_lo;
    logic [31:0]      st_hi;
  } exu_res_t;

  function automatic op_e decode_op(input logic [31:0] w);
    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
    op_e        op;
    opc = w[6:0];
    f3  = w[14:12];
    f7  = w[31:25];
    op  = OP_BAD;
    case (opc)
      OPC_REG: begin
        if (f3 == F3_ADD && f7 == F7_ADD) begin
          op = OP_ADD;
        end else if (f3 == F3_ADD && f7 == F7_SUB) begin
          op = OP_SUB;
        end
      end
      OPC_IMM: begin
        if (f3 == F3_ADD) op = OP_ADDI;
      end
      OPC_LOAD: begin
        if (f3 == F3_DWORD) op = OP_LD;
      end
      OPC_STORE: begin
        if (f3 == F3_DWORD) op = OP_SD;
      end
      OPC_BRANCH: begin
        if (f3 == F3_BEQ || f3 == F3_BNE || f3 == F3_BLT || f3 == F3_BGE) op = OP_BR;
      end
      OPC_JAL: begin
        op = OP_JAL;
      end
      default: begin
        op = OP_BAD;
      end
    endcase
    return op;
  endfunction

endpackage

>>> rtl/core/rv64_subset_core_step_unit.sv
// rv64 subset core step unit: memory writes and ignored requests finish in the simple phase,
// register reads in the register-read phase, halting or unsupported exec steps in decode,
// alu/branch/jal in execute, ld and sd in a load-wait or store-high phase; results wait in
// an output register; a new item is taken in the cycle the previous result is registered,
// paced by the registered memory reads and the single memory write port; reset clears the
// register file valid bits at once, then zeroes the 4096-word memory with in_ready_o low
module rv64_subset_core_step_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rv64cs_pkg::req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rv64cs_pkg::rsp_t   out_rsp_o
);
  import rv64cs_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SIMPLE = 3'd1;
  localparam logic [2:0] PH_RRD    = 3'd2;
  localparam logic [2:0] PH_DEC    = 3'd3;
  localparam logic [2:0] PH_EXE    = 3'd4;
  localparam logic [2:0] PH_LDW    = 3'd5;
  localparam logic [2:0] PH_SDH    = 3'd6;

  logic [2:0]       phase_q, phase_d, phase_nx;
  logic [PcW-1:0]   pc_q, pc_d;
  req_t             req_q;
  logic [31:0]      instr_q;
  op_e              op_q;
  logic [MemAw-1:0] hi_addr_q;
  logic [31:0]      st_hi_q;
  rsp_t             out_q;
  logic             out_valid_q;

  logic             fin, go, slot_free, accept;
  rsp_t             fin_rsp;
  logic             latch_instr, latch_sd;
  op_e              dec_op;
  exu_res_t         exu_res;

  mem_wr_t          mem_wr;
  logic             mem_rd_a_en, mem_rd_b_en, clr_busy;
  logic [MemAw-1:0] mem_rd_a_addr, mem_rd_b_addr;
  logic [31:0]      mem_rd_a_data, mem_rd_b_data;

  rf_wr_t           rf_wr;
  logic             rf_rd_a_en, rf_rd_b_en;
  logic [RegAw-1:0] rf_rd_a_addr, rf_rd_b_addr;
  logic [Xlen-1:0]  rf_rd_a_data, rf_rd_b_data;

  rv64cs_mem u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (mem_wr),
    .rd_a_en_i   (mem_rd_a_en),
    .rd_a_addr_i (mem_rd_a_addr),
    .rd_a_data_o (mem_rd_a_data),
    .rd_b_en_i   (mem_rd_b_en),
    .rd_b_addr_i (mem_rd_b_addr),
    .rd_b_data_o (mem_rd_b_data),
    .clr_busy_o  (clr_busy)
  );

  rv64cs_rf u_rf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (rf_wr),
    .rd_a_en_i   (rf_rd_a_en),
    .rd_a_addr_i (rf_rd_a_addr),
    .rd_a_data_o (rf_rd_a_data),
    .rd_b_en_i   (rf_rd_b_en),
    .rd_b_addr_i (rf_rd_b_addr),
    .rd_b_data_o (rf_rd_b_data)
  );

  rv64cs_exu u_exu (
    .instr_i (instr_q),
    .op_i    (op_q),
    .pc_i    (pc_q),
    .rs1_i   (rf_rd_a_data),
    .rs2_i   (rf_rd_b_data),
    .res_o   (exu_res)
  );

  assign dec_op    = decode_op(mem_rd_a_data);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    fin               = 1'b0;
    fin_rsp.status    = ST_DONE;
    fin_rsp.pc_now    = pc_q;
    fin_rsp.reg_value = '0;
    phase_nx          = phase_q;
    latch_instr       = 1'b0;
    latch_sd          = 1'b0;
    mem_wr            = '0;
    rf_wr             = '0;
    mem_rd_a_en       = 1'b0;
    mem_rd_b_en       = 1'b0;
    mem_rd_a_addr     = exu_res.lo_addr;
    mem_rd_b_addr     = exu_res.hi_addr;
    rf_rd_a_en        = 1'b0;
    rf_rd_b_en        = 1'b0;
    rf_rd_a_addr      = mem_rd_a_data[19:15];
    rf_rd_b_addr      = mem_rd_a_data[24:20];
    case (phase_q)
      PH_SIMPLE: begin
        fin            = 1'b1;
        fin_rsp.status = ST_ACC;
        mem_wr.en      = (req_q.req_type == REQ_WR) && slot_free;
        mem_wr.addr    = MemAw'(req_q.mem_addr);
        mem_wr.data    = req_q.mem_data;
      end
      PH_RRD: begin
        fin               = 1'b1;
        fin_rsp.status    = ST_ACC;
        fin_rsp.reg_value = rf_rd_a_data;
      end
      PH_DEC: begin
        if (mem_rd_a_data == '0) begin
          fin            = 1'b1;
          fin_rsp.status = ST_HALT;
        end else if (dec_op == OP_BAD) begin
          fin            = 1'b1;
          fin_rsp.status = ST_BAD;
          fin_rsp.pc_now = pc_q + 12'd1;
        end else begin
          rf_rd_a_en  = 1'b1;
          rf_rd_b_en  = 1'b1;
          latch_instr = 1'b1;
          phase_nx    = PH_EXE;
        end
      end
      PH_EXE: begin
        case (op_q)
          OP_LD: begin
            mem_rd_a_en = 1'b1;
            mem_rd_b_en = 1'b1;
            phase_nx    = PH_LDW;
          end
          OP_SD: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = exu_res.lo_addr;
            mem_wr.data = exu_res.st_lo;
            latch_sd    = 1'b1;
            phase_nx    = PH_SDH;
          end
          default: begin
            fin            = 1'b1;
            fin_rsp.pc_now = exu_res.next_pc;
            rf_wr.en       = exu_res.rf_we && slot_free;
            rf_wr.addr     = instr_q[11:7];
            rf_wr.data     = exu_res.rf_wdata;
          end
        endcase
      end
      PH_LDW: begin
        fin            = 1'b1;
        fin_rsp.pc_now = pc_q + 12'd1;
        rf_wr.en       = slot_free;
        rf_wr.addr     = instr_q[11:7];
        rf_wr.data     = {mem_rd_b_data, mem_rd_a_data};
      end
      PH_SDH: begin
        fin            = 1'b1;
        fin_rsp.pc_now = pc_q + 12'd1;
        mem_wr.en      = slot_free;
        mem_wr.addr    = hi_addr_q;
        mem_wr.data    = st_hi_q;
      end
      default: begin
        fin = 1'b0;
      end
    endcase

    // a finished item waits in its last phase while the output register is full
    go         = fin && slot_free;
    in_ready_o = !clr_busy && ((phase_q == PH_IDLE) || go);
    accept     = in_valid_i && in_ready_o;
    pc_d       = go ? fin_rsp.pc_now : pc_q;

    // first access of the new item overlaps the last phase of the previous one
    if (accept && in_req_i.req_type == REQ_EXEC) begin
      mem_rd_a_en   = 1'b1;
      mem_rd_a_addr = MemAw'(pc_d);
    end
    if (accept && in_req_i.req_type == REQ_RDREG) begin
      rf_rd_a_en   = 1'b1;
      rf_rd_a_addr = in_req_i.reg_index;
    end

    if (accept) begin
      case (in_req_i.req_type)
        REQ_EXEC:  phase_d = PH_DEC;
        REQ_RDREG: phase_d = PH_RRD;
        default:   phase_d = PH_SIMPLE;
      endcase
    end else if (go) begin
      phase_d = PH_IDLE;
    end else begin
      phase_d = phase_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pc_q    <= pc_d;
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_req_i;
    if (latch_instr) begin
      instr_q <= mem_rd_a_data;
      op_q    <= dec_op;
    end
    if (latch_sd) begin
      hi_addr_q <= exu_res.hi_addr;
      st_hi_q   <= exu_res.st_hi;
    end
    if (go) out_q <= fin_rsp;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

>>> rtl/core/rv64cs_rf.sv
// 32 x 64 register file: two registered read ports, one write port, write bypass
module rv64cs_rf (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rv64cs_pkg::rf_wr_t                  wr_i,
  input  logic                                rd_a_en_i,
  input  logic [rv64cs_pkg::RegAw-1:0]        rd_a_addr_i,
  output logic [rv64cs_pkg::Xlen-1:0]         rd_a_data_o,
  input  logic                                rd_b_en_i,
  input  logic [rv64cs_pkg::RegAw-1:0]        rd_b_addr_i,
  output logic [rv64cs_pkg::Xlen-1:0]         rd_b_data_o
);
  import rv64cs_pkg::*;

  logic [Xlen-1:0]    mem_q [NumRegs];
  logic [NumRegs-1:0] valid_q;
  logic [Xlen-1:0]    raw_a_q, raw_b_q, byp_a_data_q, byp_b_data_q;
  logic               byp_a_q, byp_b_q, vld_a_q, vld_b_q, sp_a_q, sp_b_q;
  logic               wr_ok;

  // x0 is never written, so it always reads its reset value of zero
  assign wr_ok = wr_i.en && (wr_i.addr != '0);

  always_ff @(posedge clk_i) begin
    if (wr_ok) mem_q[wr_i.addr] <= wr_i.data;
    if (rd_a_en_i) begin
      raw_a_q      <= mem_q[rd_a_addr_i];
      byp_a_data_q <= wr_i.data;
    end
    if (rd_b_en_i) begin
      raw_b_q      <= mem_q[rd_b_addr_i];
      byp_b_data_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      byp_a_q <= 1'b0;
      byp_b_q <= 1'b0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      sp_a_q  <= 1'b0;
      sp_b_q  <= 1'b0;
    end else begin
      if (wr_ok) valid_q[wr_i.addr] <= 1'b1;
      if (rd_a_en_i) begin
        byp_a_q <= wr_ok && (wr_i.addr == rd_a_addr_i);
        vld_a_q <= valid_q[rd_a_addr_i];
        sp_a_q  <= (rd_a_addr_i == SpIdx);
      end
      if (rd_b_en_i) begin
        byp_b_q <= wr_ok && (wr_i.addr == rd_b_addr_i);
        vld_b_q <= valid_q[rd_b_addr_i];
        sp_b_q  <= (rd_b_addr_i == SpIdx);
      end
    end
  end

  // an entry never written reads as its reset value
  assign rd_a_data_o = byp_a_q ? byp_a_data_q :
                       vld_a_q ? raw_a_q : (sp_a_q ? SpReset : '0);
  assign rd_b_data_o = byp_b_q ? byp_b_data_q :
                       vld_b_q ? raw_b_q : (sp_b_q ? SpReset : '0);

endmodule

>>> rtl/core/rv64cs_mem.sv
// unified word memory: two registered read ports, one write port, clearing sweep after reset
module rv64cs_mem (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rv64cs_pkg::mem_wr_t            wr_i,
  input  logic                           rd_a_en_i,
  input  logic [rv64cs_pkg::MemAw-1:0]   rd_a_addr_i,
  output logic [31:0]                    rd_a_data_o,
  input  logic                           rd_b_en_i,
  input  logic [rv64cs_pkg::MemAw-1:0]   rd_b_addr_i,
  output logic [31:0]                    rd_b_data_o,
  output logic                           clr_busy_o
);
  import rv64cs_pkg::*;

  logic [31:0]      mem_q [MemWords];
  logic [31:0]      raw_a_q, raw_b_q, byp_a_data_q, byp_b_data_q;
  logic             byp_a_q, byp_b_q;
  logic [MemAw-1:0] clr_q;
  logic             clr_busy_q;
  logic             we;
  logic [MemAw-1:0] waddr;
  logic [31:0]      wdata;

  // the clearing sweep owns the write port until it is done
  assign we    = clr_busy_q || wr_i.en;
  assign waddr = clr_busy_q ? clr_q : wr_i.addr;
  assign wdata = clr_busy_q ? '0 : wr_i.data;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (rd_a_en_i) begin
      raw_a_q      <= mem_q[rd_a_addr_i];
      byp_a_data_q <= wdata;
    end
    if (rd_b_en_i) begin
      raw_b_q      <= mem_q[rd_b_addr_i];
      byp_b_data_q <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_busy_q <= 1'b1;
      byp_a_q    <= 1'b0;
      byp_b_q    <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == MemAw'(MemWords - 1)) clr_busy_q <= 1'b0;
      end
      if (rd_a_en_i) byp_a_q <= we && (waddr == rd_a_addr_i);
      if (rd_b_en_i) byp_b_q <= we && (waddr == rd_b_addr_i);
    end
  end

  assign rd_a_data_o = byp_a_q ? byp_a_data_q : raw_a_q;
  assign rd_b_data_o = byp_b_q ? byp_b_data_q : raw_b_q;
  assign clr_busy_o  = clr_busy_q;

endmodule

>>> rtl/core/rv64cs_exu.sv
// execute unit: alu, branch compare, jump target and load/store address
module rv64cs_exu (
  input  logic [31:0]                   instr_i,
  input  rv64cs_pkg::op_e               op_i,
  input  logic [rv64cs_pkg::PcW-1:0]    pc_i,
  input  logic [rv64cs_pkg::Xlen-1:0]   rs1_i,
  input  logic [rv64cs_pkg::Xlen-1:0]   rs2_i,
  output rv64cs_pkg::exu_res_t          res_o
);
  import rv64cs_pkg::*;

  logic [Xlen-1:0]  imm_i, imm_s, imm_ls;
  logic [MemAw+1:0] ls_addr;
  logic [12:0]      braw;
  logic [20:0]      jraw;
  logic [PcW-1:0]   boff, joff, pc_inc;
  logic [2:0]       f3;
  logic             eq, lt, take;

  assign imm_i  = {{52{instr_i[31]}}, instr_i[31:20]};
  assign imm_s  = {{52{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_ls = (op_i == OP_SD) ? imm_s : imm_i;
  assign pc_inc = pc_i + 12'd1;
  assign f3     = instr_i[14:12];

  // byte offsets to word offsets, rounding toward zero for negative odd quotients
  assign braw = {instr_i[31], instr_i[7], instr_i[30:25], instr_i[11:8], 1'b0};
  assign boff = {braw[12], braw[12:2]} + {11'd0, braw[12] & braw[1]};
  assign jraw = {instr_i[31], instr_i[19:12], instr_i[20], instr_i[30:21], 1'b0};
  assign joff = jraw[13:2] + {11'd0, jraw[20] & jraw[1]};

  // only the word index bits of the byte address matter
  assign ls_addr = rs1_i[MemAw+1:0] + imm_ls[MemAw+1:0];

  assign eq = (rs1_i == rs2_i);
  assign lt = ($signed(rs1_i) < $signed(rs2_i));

  always_comb begin
    case (f3)
      F3_BEQ:  take = eq;
      F3_BNE:  take = !eq;
      F3_BLT:  take = lt;
      F3_BGE:  take = !lt;
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    res_o          = '0;
    res_o.next_pc  = pc_inc;
    res_o.lo_addr  = ls_addr[MemAw+1:2];
    res_o.hi_addr  = ls_addr[MemAw+1:2] + 1'b1;
    res_o.st_lo    = rs2_i[31:0];
    res_o.st_hi    = rs2_i[63:32];
    case (op_i)
      OP_ADD: begin
        res_o.rf_we    = 1'b1;
        res_o.rf_wdata = rs1_i + rs2_i;
      end
      OP_SUB: begin
        res_o.rf_we    = 1'b1;
        res_o.rf_wdata = rs1_i - rs2_i;
      end
      OP_ADDI: begin
        res_o.rf_we    = 1'b1;
        res_o.rf_wdata = rs1_i + imm_i;
      end
      OP_BR: begin
        if (take) res_o.next_pc = pc_i + boff;
      end
      OP_JAL: begin
        res_o.rf_we    = 1'b1;
        res_o.rf_wdata = {{(Xlen-PcW){1'b0}}, pc_inc};
        res_o.next_pc  = pc_i + joff;
      end
      default: begin
        res_o.rf_we = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/core/rv64cs_chk.sv
// port-level checker for the rv64 subset core step unit, bound to the top level
module rv64cs_chk (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input rv64cs_pkg::req_t in_req_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input rv64cs_pkg::rsp_t out_rsp_o
);
  import rv64cs_pkg::*;

  logic [2:0] cnt_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // items taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_req_i))
    else $error("input item dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result dropped or changed while stalled");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_ACC |-> out_rsp_o.reg_value == '0)
    else $error("nonzero register value on a step result");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("result without an accepted item");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd2)
    else $error("more than two items in flight");

endmodule

bind rv64_subset_core_step_unit rv64cs_chk u_rv64cs_chk (.*);

>>> test/rv64cs_step_checker.sv
// checker for the rv64 subset core step unit: predicts every result and compares it
`timescale 1ns / 100ps
module rv64cs_step_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  rv64cs_pkg::req_t           in_req_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  rv64cs_pkg::rsp_t           out_rsp_i,
  output int unsigned                pending_o,
  output int unsigned                errors_o,
  output logic [rv64cs_pkg::PcW-1:0] model_pc_o
);
  import rv64cs_pkg::*;

  logic [Xlen-1:0] xreg [NumRegs];
  logic [PcW-1:0]  core_pc;
  logic [31:0]     core_mem [MemWords];
  rsp_t            expected_rsp_q [$];
  int unsigned     n_results;

  function automatic logic [Xlen-1:0] read_xreg(input logic [RegAw-1:0] r);
    return (r == '0) ? '0 : xreg[r];
  endfunction

  task automatic write_xreg(input logic [RegAw-1:0] r, input logic [Xlen-1:0] v);
    if (r != '0) xreg[r] = v;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors_o++;
    if (errors_o <= 100) begin
      $display("mismatch on result %0d: %s got %h want %h", n_results, what, got, want);
    end
  endtask

  // executes the word at the program counter
  task automatic step_core(output status_e st);
    logic [31:0]        w;
    logic [6:0]         opc;
    logic [6:0]         f7;
    logic [2:0]         f3;
    logic [RegAw-1:0]   rd;
    logic [RegAw-1:0]   rs1;
    logic [RegAw-1:0]   rs2;
    logic [Xlen-1:0]    a;
    logic [Xlen-1:0]    b;
    logic [Xlen-1:0]    imm;
    logic [Xlen-1:0]    addr;
    logic [MemAw-1:0]   lo;
    logic [MemAw-1:0]   hi;
    logic [PcW-1:0]     nxt;
    logic signed [12:0] boff;
    logic signed [20:0] joff;
    logic               take;
    w   = core_mem[core_pc];
    nxt = core_pc + 1'b1;
    if (w == '0) begin
      st = ST_HALT;
      return;
    end
    opc = w[6:0];
    f3  = w[14:12];
    f7  = w[31:25];
    rd  = w[11:7];
    rs1 = w[19:15];
    rs2 = w[24:20];
    a   = read_xreg(rs1);
    b   = read_xreg(rs2);
    st  = ST_DONE;
    if (opc == OPC_REG && f3 == F3_ADD && (f7 == F7_ADD || f7 == F7_SUB)) begin
      write_xreg(rd, (f7 == F7_ADD) ? a + b : a - b);
    end else if (opc == OPC_IMM && f3 == F3_ADD) begin
      write_xreg(rd, a + {{(Xlen-12){w[31]}}, w[31:20]});
    end else if ((opc == OPC_LOAD || opc == OPC_STORE) && f3 == F3_DWORD) begin
      if (opc == OPC_LOAD) begin
        imm = {{(Xlen-12){w[31]}}, w[31:20]};
      end else begin
        imm = {{(Xlen-12){w[31]}}, w[31:25], w[11:7]};
      end
      addr = a + imm;
      lo   = addr[MemAw+1:2];
      hi   = lo + 1'b1;
      if (opc == OPC_LOAD) begin
        write_xreg(rd, {core_mem[hi], core_mem[lo]});
      end else begin
        core_mem[lo] = b[31:0];
        core_mem[hi] = b[63:32];
      end
    end else if (opc == OPC_BRANCH &&
                 (f3 == F3_BEQ || f3 == F3_BNE || f3 == F3_BLT || f3 == F3_BGE)) begin
      case (f3)
        F3_BEQ:  take = (a == b);
        F3_BNE:  take = (a != b);
        F3_BLT:  take = ($signed(a) < $signed(b));
        default: take = !($signed(a) < $signed(b));
      endcase
      boff = {w[31], w[7], w[30:25], w[11:8], 1'b0};
      // byte offset to word offset, rounding toward zero
      if (take) nxt = core_pc + PcW'(int'(boff) / 4);
    end else if (opc == OPC_JAL) begin
      joff = {w[31], w[19:12], w[20], w[30:21], 1'b0};
      write_xreg(rd, {{(Xlen-PcW){1'b0}}, nxt});
      nxt = core_pc + PcW'(int'(joff) / 4);
    end else begin
      st = ST_BAD;
    end
    core_pc = nxt;
  endtask

  task automatic predict_item(input req_t item, output rsp_t want);
    status_e st;
    want = '0;
    st   = ST_ACC;
    case (item.req_type)
      REQ_WR:    core_mem[item.mem_addr] = item.mem_data;
      REQ_EXEC:  step_core(st);
      REQ_RDREG: want.reg_value = read_xreg(item.reg_index);
      default: ;
    endcase
    want.status = st;
    want.pc_now = core_pc;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) xreg[i] = '0;
      xreg[SpIdx] = SpReset;
      for (int i = 0; i < MemWords; i++) core_mem[i] = '0;
      core_pc = '0;
      expected_rsp_q.delete();
      n_results  = 0;
      pending_o  = 0;
      errors_o   = 0;
      model_pc_o = '0;
    end else begin
      // results first: an item accepted at this edge cannot be answered at the same edge
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("result with no item pending", out_rsp_i.reg_value, '0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_rsp_i.status !== want.status) begin
            report_mismatch("status", 64'(out_rsp_i.status), 64'(want.status));
          end
          if (out_rsp_i.pc_now !== want.pc_now) begin
            report_mismatch("pc_now", 64'(out_rsp_i.pc_now), 64'(want.pc_now));
          end
          if (out_rsp_i.reg_value !== want.reg_value) begin
            report_mismatch("reg_value", out_rsp_i.reg_value, want.reg_value);
          end
        end
        n_results++;
      end
      if (in_valid_i && in_ready_i) begin
        predict_item(in_req_i, want);
        expected_rsp_q.push_back(want);
      end
      pending_o  = expected_rsp_q.size();
      model_pc_o = core_pc;
    end
  end

endmodule

>>> test/tb_rv64_subset_core_step_unit.sv
// testbench top for the rv64 subset core step unit: stimulus, handshakes and verdict
`timescale 1ns / 100ps
module tb_rv64_subset_core_step_unit;
  import rv64cs_pkg::*;

  typedef enum int {
    IK_ADD, IK_SUB, IK_ADDI, IK_LD, IK_SD, IK_BEQ, IK_BNE, IK_BLT, IK_BGE, IK_JAL, IK_BAD,
    IK_ZERO
  } instr_kind_e;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  req_t           in_req_i;
  logic           out_valid_o;
  logic           out_ready_i;
  rsp_t           out_rsp_o;
  int unsigned    pending_cnt;
  int unsigned    error_cnt;
  logic [PcW-1:0] model_pc;

  bit             tx_calm;
  int unsigned    n_sent;

  rv64_subset_core_step_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  rv64cs_step_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_i   (out_rsp_o),
    .pending_o   (pending_cnt),
    .errors_o    (error_cnt),
    .model_pc_o  (model_pc)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [4:0] rd);
    return {f7, rs2, rs1, F3_ADD, rd, OPC_REG};
  endfunction

  function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [2:0] f3,
                                        input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [4:0] rd);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                        input logic [4:0] rs1);
    return {imm[11:5], rs2, rs1, F3_DWORD, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(input logic [2:0] f3, input logic [12:0] imm,
                                        input logic [4:0] rs2, input logic [4:0] rs1);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [4:0] pick_reg();
    // favor the low registers so results feed later instructions
    return ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom());
  endfunction

  function automatic logic [31:0] gen_instr();
    instr_kind_e kind;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [11:0] imm12;
    logic [12:0] imm13;
    logic [20:0] imm21;
    logic [2:0]  br_f3;
    logic [31:0] w;
    int          v;
    kind = instr_kind_e'($urandom_range(0, IK_ZERO));
    if (kind == IK_ZERO && $urandom_range(0, 3) != 0) kind = IK_ADDI;
    rd  = pick_reg();
    rs1 = pick_reg();
    rs2 = pick_reg();
    if ($urandom_range(0, 3) == 0) rs2 = rs1;
    imm12 = 12'($urandom());
    if ($urandom_range(0, 1) != 0) imm12 = 12'(int'($urandom_range(0, 64)) - 32);
    v = int'($urandom_range(0, 16)) - 8;
    imm13 = 13'(v * 2);
    if ($urandom_range(0, 7) == 0) imm13 = 13'($urandom());
    v = int'($urandom_range(0, 24)) - 12;
    imm21 = 21'(v * 2);
    if ($urandom_range(0, 7) == 0) imm21 = 21'($urandom());
    br_f3 = (kind == IK_BEQ) ? F3_BEQ : (kind == IK_BNE) ? F3_BNE :
            (kind == IK_BLT) ? F3_BLT : F3_BGE;
    case (kind)
      IK_ADD:  w = enc_r(F7_ADD, rs2, rs1, rd);
      IK_SUB:  w = enc_r(F7_SUB, rs2, rs1, rd);
      IK_ADDI: w = enc_i(OPC_IMM, F3_ADD, imm12, rs1, rd);
      IK_LD:   w = enc_i(OPC_LOAD, F3_DWORD, imm12, rs1, rd);
      IK_SD:   w = enc_s(imm12, rs2, rs1);
      IK_BEQ, IK_BNE, IK_BLT, IK_BGE: w = enc_b(br_f3, imm13, rs2, rs1);
      IK_JAL:  w = enc_j(imm21, rd);
      IK_BAD: begin
        // mostly near misses on a known opcode with random function bits
        w = $urandom();
        case ($urandom_range(0, 4))
          0: w[6:0] = OPC_REG;
          1: w[6:0] = OPC_BRANCH;
          2: w[6:0] = OPC_LOAD;
          3: w[6:0] = OPC_STORE;
          default: ;
        endcase
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic req_t mk_write(input logic [11:0] addr, input logic [31:0] data);
    req_t r;
    r = '0;
    r.req_type = REQ_WR;
    r.mem_addr = addr;
    r.mem_data = data;
    return r;
  endfunction

  function automatic req_t mk_exec();
    req_t r;
    r = '0;
    r.req_type = REQ_EXEC;
    return r;
  endfunction

  function automatic req_t mk_read(input logic [4:0] idx);
    req_t r;
    r = '0;
    r.req_type  = REQ_RDREG;
    r.reg_index = idx;
    return r;
  endfunction

  // called and returning at a falling edge
  task automatic send_item(input req_t item);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= item;
    do @(posedge clk_i); while (!in_ready_o);
    if (item.req_type != REQ_NONE) n_sent++;
    @(negedge clk_i);
  endtask

  // writes a short program at the current pc and steps through it
  task automatic run_program();
    logic [PcW-1:0] base;
    int unsigned    len;
    int unsigned    steps;
    base  = model_pc;
    len   = $urandom_range(1, 8);
    steps = len + $urandom_range(0, 2);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(mk_write(base + PcW'(i), gen_instr()));
    end
    for (int unsigned i = 0; i < steps; i++) begin
      send_item(mk_exec());
      if ($urandom_range(0, 5) == 0) send_item(mk_read(pick_reg()));
    end
  endtask

  // result side: random stalls, plus two long hold-offs that back up the block
  initial begin
    int unsigned gap;
    int unsigned n_taken;
    bit          rx_calm;
    out_ready_i = 1'b0;
    n_taken     = 0;
    rx_calm     = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      if (n_taken == 300 || n_taken == 800) begin
        out_ready_i <= 1'b0;
        repeat (200) @(negedge clk_i);
      end
      gap = rx_calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      n_taken++;
      @(negedge clk_i);
    end
  end

  initial begin
    #(8_000_000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned sel;
    int unsigned waited;
    bit          drained;
    req_t        noise;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    tx_calm    = 1'b0;
    n_sent     = 0;
    drained    = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values, halt on cleared memory, ignored request
    send_item(mk_read(5'd2));
    send_item(mk_read(5'd31));
    send_item(mk_exec());
    noise          = '0;
    noise.req_type = REQ_NONE;
    send_item(noise);
    // jal backwards from word 0 wraps the pc, then an unknown opcode wraps it back
    send_item(mk_write(12'hfff, 32'hffff_ffff));
    send_item(mk_write(12'h000, enc_j(21'h1f_fffc, 5'd1)));
    send_item(mk_exec());
    send_item(mk_exec());
    // x0 write dropped, load and store across the memory wrap, taken signed branch
    send_item(mk_write(12'h000, enc_i(OPC_IMM, F3_ADD, 12'h001, 5'd2, 5'd0)));
    send_item(mk_write(12'h001, enc_i(OPC_IMM, F3_ADD, 12'hffc, 5'd0, 5'd5)));
    send_item(mk_write(12'h002, enc_s(12'h000, 5'd2, 5'd5)));
    send_item(mk_write(12'h003, enc_i(OPC_LOAD, F3_DWORD, 12'h000, 5'd5, 5'd6)));
    send_item(mk_write(12'h004, enc_r(F7_SUB, 5'd2, 5'd0, 5'd7)));
    send_item(mk_write(12'h005, enc_b(F3_BLT, 13'd8, 5'd0, 5'd7)));
    send_item(mk_write(12'h007, enc_r(F7_ADD, 5'd6, 5'd7, 5'd8)));
    repeat (7) send_item(mk_exec());
    send_item(mk_read(5'd0));
    send_item(mk_read(5'd6));

    while (n_sent < 1300) begin
      if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
      sel = $urandom_range(0, 19);
      if (sel < 13) begin
        run_program();
      end else if (sel < 15) begin
        repeat ($urandom_range(1, 4)) send_item(mk_read(5'($urandom())));
      end else if (sel < 17) begin
        repeat ($urandom_range(1, 4)) send_item(mk_write(12'($urandom()), $urandom()));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          noise.req_type  = req_e'($urandom_range(0, 3));
          noise.mem_addr  = 12'($urandom());
          noise.mem_data  = $urandom();
          noise.reg_index = 5'($urandom());
          send_item(noise);
        end
      end
      // once in mid run, hold the input until the block has answered everything
      if (!drained && n_sent >= 650) begin
        drained = 1'b1;
        in_valid_i <= 1'b0;
        while (pending_cnt != 0) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (pending_cnt != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (10) @(negedge clk_i);
    if (error_cnt == 0 && pending_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> rv64_subset_core_step_unit.f
rtl/core/rv64cs_pkg.sv
rtl/core/rv64cs_rf.sv
rtl/core/rv64cs_mem.sv
rtl/core/rv64cs_exu.sv
rtl/core/rv64_subset_core_step_unit.sv
rtl/core/rv64cs_chk.sv
test/rv64cs_step_checker.sv
test/tb_rv64_subset_core_step_unit.sv
